// ===== hdl/fqkr_pkg.sv =====
// ----------------------------------------------------------------------------
// Queue with keyed removal: shared package
// Sizes, request codes, store control bundle and the circular address helper
// used by the queue controller and its entry store.
// ----------------------------------------------------------------------------
package fqkr_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_W        = 32;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;

   // Request codes carried in the req_type field.
   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // Control bundle from the sequencer to the entry store. Offsets are
   // positions counted from the head of the queue.
   typedef struct packed {
      logic              wr_en;
      logic [CNT_W-1:0]  wr_off;
      logic [ID_W-1:0]   wr_data;
      logic [CNT_W-1:0]  rd_off;
   } store_ctl_type;

   // Add a queue position to the head slot and wrap around the store.
   // The offset is always below QUEUE_DEPTH, so one subtract suffices.
   function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ===== hdl/fqkr_store.sv =====
// ----------------------------------------------------------------------------
// Queue with keyed removal: entry store
// Circular entry memory with one write port and one registered read port,
// both addressed by position relative to the current head slot.
// ----------------------------------------------------------------------------
module fqkr_store (
   input  logic                          clock,
   input  logic [fqkr_pkg::ADDR_W-1:0]   head,
   input  fqkr_pkg::store_ctl_type       ctl,
   output logic [fqkr_pkg::ID_W-1:0]     rd_data
);
   import fqkr_pkg::*;

   logic [ID_W-1:0]   mem [QUEUE_DEPTH];
   logic [ID_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   // Translate queue positions into physical slots.
   assign wr_addr = addr_add(head, ctl.wr_off);
   assign rd_addr = addr_add(head, ctl.rd_off);

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fifo_queue_with_keyed_removal.sv =====
// ----------------------------------------------------------------------------
// Queue with keyed removal: top level
// First-in first-out queue of 32-bit identifiers with push, pop and removal
// of the oldest entry that matches a given identifier.
// ----------------------------------------------------------------------------
// The queue holds up to 16 signed 32-bit identifiers. Each request pushes at
// the tail, pops the head, or removes the oldest entry equal to req_entry_id,
// and produces exactly one response with the new head (-1 when empty), an
// empty flag, a removed flag and an overflow flag for a push to a full queue.
// The block works on one request at a time and holds req_stall high while
// busy. All work goes through one entry memory with one write port and one
// registered read port, driven by a small sequencer: every request ends with
// a head read and the response; a removal first reads and compares entries
// from the head in turn and, on a hit, moves each younger entry down one
// position to close the gap. A waiting response does not block acceptance
// of the next request, but that request's response waits until the previous
// one is taken.
module fifo_queue_with_keyed_removal (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic signed [fqkr_pkg::ID_W-1:0]   req_entry_id,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fqkr_pkg::ID_W-1:0]   rsp_front_id,
   output logic                               rsp_is_empty,
   output logic                               rsp_removed,
   output logic                               rsp_overflow
);
   import fqkr_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SCAN_RD  = 7'b0000010,
      ST_SCAN_CMP = 7'b0000100,
      ST_SHIFT_RD = 7'b0001000,
      ST_SHIFT_WR = 7'b0010000,
      ST_HEAD_RD  = 7'b0100000,
      ST_RESP     = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [ID_W-1:0]   key_ff, key_in;
   logic              removed_ff, removed_in;
   logic              overflow_ff, overflow_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_front_ff, rsp_front_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_removed_ff, rsp_removed_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   store_ctl_type     ctl;
   logic [ID_W-1:0]   rd_data;
   logic              accept;
   logic              more_scan;
   logic              more_shift;

   // Entry memory.
   fqkr_store u_store (
      .clock   (clock),
      .head    (head_ff),
      .ctl     (ctl),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Whether another entry follows the current scan or shift position.
   assign more_scan  = (SUM_W'(idx_ff) + SUM_W'(1)) < SUM_W'(count_ff);
   assign more_shift = (SUM_W'(idx_ff) + SUM_W'(2)) < SUM_W'(count_ff);

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      key_in          = key_ff;
      removed_in      = removed_ff;
      overflow_in     = overflow_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_front_in    = rsp_front_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_overflow_in = rsp_overflow_ff;
      ctl.wr_en       = 1'b0;
      ctl.wr_off      = idx_ff;
      ctl.wr_data     = rd_data;
      ctl.rd_off      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in      = req_entry_id;
               removed_in  = 1'b0;
               overflow_in = 1'b0;
               idx_in      = '0;
               state_in    = ST_HEAD_RD;
               unique case (req_type)
                  REQ_PUSH: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        overflow_in = 1'b1;
                     end else begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_off  = count_ff;
                        ctl.wr_data = req_entry_id;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_POP: begin
                     if (count_ff != '0) begin
                        head_in  = addr_add(head_ff, CNT_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  default: begin
                     state_in = ST_HEAD_RD;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            ctl.rd_off = idx_ff;
            state_in   = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // Compare the entry just read; on a hit close the gap behind it.
            if (rd_data == key_ff) begin
               removed_in = 1'b1;
               if (more_scan) begin
                  state_in = ST_SHIFT_RD;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_HEAD_RD;
               end
            end else if (more_scan) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_HEAD_RD;
            end
         end
         ST_SHIFT_RD: begin
            ctl.rd_off = idx_ff + CNT_W'(1);
            state_in   = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            // Move the younger entry down by one position.
            ctl.wr_en   = 1'b1;
            ctl.wr_off  = idx_ff;
            ctl.wr_data = rd_data;
            if (more_shift) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SHIFT_RD;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            ctl.rd_off = '0;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            // Load the response once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_front_in    = (count_ff != '0) ? rd_data : {ID_W{1'b1}};
               rsp_empty_in    = (count_ff == '0);
               rsp_removed_in  = removed_ff;
               rsp_overflow_in = overflow_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      key_ff          <= key_in;
      removed_ff      <= removed_in;
      overflow_ff     <= overflow_in;
      rsp_front_ff    <= rsp_front_in;
      rsp_empty_ff    <= rsp_empty_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_front_id = rsp_front_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_removed  = rsp_removed_ff;
   assign rsp_overflow = rsp_overflow_ff;

`ifndef NO_ASSERTIONS
   // The entry count never goes beyond the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   // A dropped push means the queue was full, and no removal happened.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> !rsp_empty_ff && !rsp_removed_ff)
      else $error("overflow reported with empty queue or removal");

   // An empty queue reports -1 as its head.
   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_front_ff == {ID_W{1'b1}})
      else $error("empty queue reports a head other than -1");

   // An accepted request always starts the sequencer.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after a request");
`endif

endmodule
